### hw/rtl/grid_rectangle_allocator_core_defines.svh
// Assertion macros for the grid rectangle allocator.
`ifndef GRID_RECTANGLE_ALLOCATOR_CORE_DEFINES_SVH
`define GRID_RECTANGLE_ALLOCATOR_CORE_DEFINES_SVH

// Assert that an antecedent implies a consequent on the same edge.
`define GRA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert that an antecedent implies a consequent on the next edge.
`define GRA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/gra_pkg.sv
// ----------------------------------------------------------------------------
// Grid rectangle allocator package
// Shared types, sizes and codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gra_pkg;

    localparam int ROWS       = 16;
    localparam int COLS       = 16;
    localparam int OWNER_BITS = 8;
    localparam int CELLS      = ROWS * COLS;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int RC_W       = $clog2(ROWS) > $clog2(COLS) ? $clog2(ROWS) + 1 : $clog2(COLS) + 1;
    localparam int MAX_RADIUS = ROWS > COLS ? ROWS : COLS;
    localparam int K_W        = $clog2(MAX_RADIUS + 1);

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOSPACE  = 3'd1;
    localparam logic [2:0] ST_INVALID  = 3'd2;
    localparam logic [2:0] ST_OCCUPIED = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    localparam logic [1:0] MODE_FIRST   = 2'd0;
    localparam logic [1:0] MODE_NEAR    = 2'd1;
    localparam logic [1:0] MODE_EXACT   = 2'd2;
    localparam logic [1:0] MODE_RELEASE = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] owner_id;
        logic [4:0] width_cells;
        logic [4:0] height_cells;
        logic [3:0] start_col;
        logic [3:0] start_row;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] placed_col;
        logic [3:0] placed_row;
    } t_out_item;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_CAND,
        S_CHECK,
        S_CHECK_WAIT,
        S_NEXT,
        S_FILL,
        S_REL,
        S_REL_WAIT,
        S_DONE
    } t_state;

    // memory port request from sequencer
    typedef struct packed {
        logic                  rd;
        logic                  wr;
        logic [ADDR_W-1:0]     addr;
        logic [OWNER_BITS-1:0] wdata;
    } t_mem_req;

endpackage

### hw/rtl/gra_grid_mem.sv
// ----------------------------------------------------------------------------
// Grid cell memory
// One entry per cell holding the owner id; registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gra_grid_mem (
    input  logic                           i_clk,
    input  gra_pkg::t_mem_req              i_req,
    output logic [gra_pkg::OWNER_BITS-1:0] o_rdata
);

    logic [gra_pkg::OWNER_BITS-1:0] r_mem [gra_pkg::CELLS];

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd) begin
            o_rdata <= r_mem[i_req.addr];
        end
    end

endmodule

### hw/rtl/gra_seq.sv
// ----------------------------------------------------------------------------
// Allocation sequencer
// Walks candidates and cells one memory access at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gra_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  gra_pkg::t_in_item              i_item,
    output logic                           o_stall,
    output logic                           o_valid,
    input  logic                           i_stall,
    output gra_pkg::t_out_item             o_item,
    output gra_pkg::t_mem_req              o_req,
    input  logic [gra_pkg::OWNER_BITS-1:0] i_rdata,
    output gra_pkg::t_state                o_state
);

    localparam int RC = gra_pkg::RC_W;
    localparam int RW = $clog2(gra_pkg::ROWS);
    localparam int CW = $clog2(gra_pkg::COLS);

    gra_pkg::t_state r_state, n_state;

    logic [1:0]                  r_mode, n_mode;
    logic [gra_pkg::OWNER_BITS-1:0] r_owner, n_owner;
    logic signed [RC:0]          r_w, n_w, r_h, n_h;
    logic signed [RC:0]          r_sc, n_sc, r_sr, n_sr;
    logic signed [RC:0]          r_cc, n_cc, r_cr, n_cr;   // candidate
    logic signed [RC:0]          r_dc, n_dc, r_dr, n_dr;   // offset in rect
    logic                        r_ff, n_ff;               // in first-fit scan
    logic [gra_pkg::K_W-1:0]     r_k, n_k;
    logic [1:0]                  r_dir, n_dir;
    logic                        r_found, n_found;
    logic [gra_pkg::ADDR_W:0]    r_idx, n_idx;
    logic                        r_ovalid, n_ovalid;
    gra_pkg::t_out_item          r_out, n_out;

    logic signed [RC:0] v_c, v_r, v_kk;
    logic               v_inb;
    logic [RW-1:0]      v_row;
    logic [CW-1:0]      v_col;

    assign o_state = r_state;
    assign o_stall = (r_state != gra_pkg::S_IDLE) || r_ovalid;
    assign o_valid = r_ovalid;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gra_pkg::S_CLEAR;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
        end
        r_mode  <= n_mode;  r_owner <= n_owner;
        r_w     <= n_w;     r_h     <= n_h;
        r_sc    <= n_sc;    r_sr    <= n_sr;
        r_cc    <= n_cc;    r_cr    <= n_cr;
        r_dc    <= n_dc;    r_dr    <= n_dr;
        r_ff    <= n_ff;    r_k     <= n_k;
        r_dir   <= n_dir;   r_found <= n_found;
        r_out   <= n_out;
    end

    always_comb begin
        n_state = r_state;  n_mode = r_mode;  n_owner = r_owner;
        n_w = r_w;  n_h = r_h;  n_sc = r_sc;  n_sr = r_sr;
        n_cc = r_cc;  n_cr = r_cr;  n_dc = r_dc;  n_dr = r_dr;
        n_ff = r_ff;  n_k = r_k;  n_dir = r_dir;  n_found = r_found;
        n_idx = r_idx;  n_ovalid = r_ovalid;  n_out = r_out;
        o_req = '0;
        v_c = r_cc + r_dc;
        v_r = r_cr + r_dr;
        v_row = v_r[RW-1:0];
        v_col = v_c[CW-1:0];
        v_kk = (RC+1)'(r_k);
        v_inb = (r_cc >= 0) && (r_cr >= 0) && (r_cc + r_w <= gra_pkg::COLS)
             && (r_cr + r_h <= gra_pkg::ROWS);
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            gra_pkg::S_CLEAR: begin
                o_req.wr   = 1'b1;
                o_req.addr = r_idx[gra_pkg::ADDR_W-1:0];
                n_idx = r_idx + 1'b1;
                if (r_idx == (gra_pkg::ADDR_W+1)'(gra_pkg::CELLS - 1)) begin
                    n_state = gra_pkg::S_IDLE;
                end
            end
            gra_pkg::S_IDLE: begin
                if (i_valid && !r_ovalid) begin
                    n_mode  = i_item.mode;
                    n_owner = gra_pkg::OWNER_BITS'(i_item.owner_id);
                    n_w  = (RC+1)'(i_item.width_cells);
                    n_h  = (RC+1)'(i_item.height_cells);
                    n_sc = (RC+1)'(i_item.start_col);
                    n_sr = (RC+1)'(i_item.start_row);
                    n_state = gra_pkg::S_DECODE;
                end
            end
            gra_pkg::S_DECODE: begin
                n_out = '0;
                n_found = 1'b0;
                n_k = '0;
                n_dir = '0;
                n_dc = '0;
                n_dr = '0;
                n_cc = r_sc;
                n_cr = r_sr;
                n_ff = (r_mode == gra_pkg::MODE_FIRST);
                if (r_mode == gra_pkg::MODE_FIRST) begin
                    n_cc = '0;
                    n_cr = '0;
                end
                if (r_owner == '0) begin
                    n_out.status = gra_pkg::ST_INVALID;
                    n_state = gra_pkg::S_DONE;
                end else if (r_mode == gra_pkg::MODE_RELEASE) begin
                    n_idx = '0;
                    n_state = gra_pkg::S_REL;
                end else if (r_w == 0 || r_h == 0) begin
                    n_out.status = gra_pkg::ST_INVALID;
                    n_state = gra_pkg::S_DONE;
                end else if (r_mode == gra_pkg::MODE_EXACT
                             && (r_sc + r_w > gra_pkg::COLS
                                 || r_sr + r_h > gra_pkg::ROWS)) begin
                    n_out.status = gra_pkg::ST_INVALID;
                    n_state = gra_pkg::S_DONE;
                end else begin
                    n_state = gra_pkg::S_CAND;
                end
            end
            gra_pkg::S_CAND: begin
                n_dc = '0;
                n_dr = '0;
                if (v_inb) begin
                    n_state = gra_pkg::S_CHECK;
                end else begin
                    n_state = gra_pkg::S_NEXT;
                end
            end
            gra_pkg::S_CHECK: begin
                o_req.rd   = 1'b1;
                o_req.addr = {v_row, v_col};
                n_state = gra_pkg::S_CHECK_WAIT;
            end
            gra_pkg::S_CHECK_WAIT: begin
                if (i_rdata != '0) begin
                    n_state = gra_pkg::S_NEXT;
                end else if (r_dc + 1 < r_w) begin
                    n_dc = r_dc + (RC+1)'(1);
                    n_state = gra_pkg::S_CHECK;
                end else if (r_dr + 1 < r_h) begin
                    n_dc = '0;
                    n_dr = r_dr + (RC+1)'(1);
                    n_state = gra_pkg::S_CHECK;
                end else begin
                    n_dc = '0;
                    n_dr = '0;
                    n_out.placed_col = r_cc[3:0];
                    n_out.placed_row = r_cr[3:0];
                    n_state = gra_pkg::S_FILL;
                end
            end
            gra_pkg::S_NEXT: begin
                n_state = gra_pkg::S_CAND;
                if (r_mode == gra_pkg::MODE_EXACT) begin
                    n_out.status = gra_pkg::ST_OCCUPIED;
                    n_state = gra_pkg::S_DONE;
                end else if (r_ff) begin
                    if (r_cc + r_w < gra_pkg::COLS) begin
                        n_cc = r_cc + (RC+1)'(1);
                    end else if (r_cr + r_h < gra_pkg::ROWS) begin
                        n_cc = '0;
                        n_cr = r_cr + (RC+1)'(1);
                    end else begin
                        n_out.status = gra_pkg::ST_NOSPACE;
                        n_state = gra_pkg::S_DONE;
                    end
                end else begin
                    // advance ring search: down, left, up, right
                    if (r_k == '0 || r_dir == 2'd3) begin
                        n_k = r_k + 1'b1;
                        n_dir = 2'd0;
                        v_kk = (RC+1)'(r_k) + 1'b1;
                    end else begin
                        n_dir = r_dir + 1'b1;
                    end
                    if (n_k == gra_pkg::K_W'(gra_pkg::MAX_RADIUS)) begin
                        n_ff = 1'b1;
                        n_cc = '0;
                        n_cr = '0;
                    end else begin
                        case (n_dir)
                            2'd0: begin n_cc = r_sc;        n_cr = r_sr + v_kk; end
                            2'd1: begin n_cc = r_sc - v_kk; n_cr = r_sr;        end
                            2'd2: begin n_cc = r_sc;        n_cr = r_sr - v_kk; end
                            default: begin n_cc = r_sc + v_kk; n_cr = r_sr;     end
                        endcase
                    end
                end
            end
            gra_pkg::S_FILL: begin
                o_req.wr    = 1'b1;
                o_req.addr  = {v_row, v_col};
                o_req.wdata = r_owner;
                if (r_dc + 1 < r_w) begin
                    n_dc = r_dc + (RC+1)'(1);
                end else if (r_dr + 1 < r_h) begin
                    n_dc = '0;
                    n_dr = r_dr + (RC+1)'(1);
                end else begin
                    n_out.status = gra_pkg::ST_OK;
                    n_state = gra_pkg::S_DONE;
                end
            end
            gra_pkg::S_REL: begin
                o_req.rd   = 1'b1;
                o_req.addr = r_idx[gra_pkg::ADDR_W-1:0];
                n_state = gra_pkg::S_REL_WAIT;
            end
            gra_pkg::S_REL_WAIT: begin
                if (i_rdata == r_owner) begin
                    o_req.wr   = 1'b1;
                    o_req.addr = r_idx[gra_pkg::ADDR_W-1:0];
                    n_found = 1'b1;
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == (gra_pkg::ADDR_W+1)'(gra_pkg::CELLS - 1)) begin
                    n_out.status = (n_found) ? gra_pkg::ST_OK : gra_pkg::ST_NOTFOUND;
                    n_state = gra_pkg::S_DONE;
                end else begin
                    n_state = gra_pkg::S_REL;
                end
            end
            gra_pkg::S_DONE: begin
                n_ovalid = 1'b1;
                n_state = gra_pkg::S_IDLE;
            end
            default: begin
                n_state = gra_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/grid_rectangle_allocator_core.sv
// ----------------------------------------------------------------------------
// Grid rectangle allocator core
// Places, near-places, exact-places and releases rectangles on a cell grid.
// ----------------------------------------------------------------------------
// One request is handled at a time through a single-port grid memory with a
// registered read. A placement passes a decode state, then tries candidates:
// each takes a candidate state, a read and a read-wait state per cell read,
// and a next state if it fails. It ends with a fill write per cell and a
// final done state. A release reads every cell and clears those holding its
// owner id; an invalid request goes from decode to done. After reset a clearing
// pass zeroes every cell before the first item is taken. Each result sits in an
// output register, and no new item is taken until that result has left.
`timescale 1ns / 1ps
`include "grid_rectangle_allocator_core_defines.svh"

module grid_rectangle_allocator_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  gra_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output gra_pkg::t_out_item  o_item
);

    gra_pkg::t_mem_req              w_req;
    logic [gra_pkg::OWNER_BITS-1:0] w_rdata;
    gra_pkg::t_state                w_state;

    gra_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item),
        .o_req   (w_req),
        .i_rdata (w_rdata),
        .o_state (w_state)
    );

    gra_grid_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    `GRA_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, w_state != gra_pkg::S_IDLE, o_stall, "accepting while busy")
    `GRA_ASSERT_NXT(a_done_valid, i_clk, i_rst_n, w_state == gra_pkg::S_DONE, o_valid, "result not raised")
    `GRA_ASSERT_IMP(a_status_range, i_clk, i_rst_n, o_valid, o_item.status <= gra_pkg::ST_NOTFOUND, "bad status")

endmodule
